// ===== hdl/tmm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and tables of the model matrix core.
// Used by every module of the block; depends on nothing else.
package tmm_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DW          = 32;
  localparam int unsigned Q_BITS      = 30;
  localparam int unsigned FULL_DEG    = 360 << FRAC_BITS;
  localparam int unsigned QUARTER_DEG = 90 << FRAC_BITS;
  localparam int unsigned HALF_Q_DEG  = QUARTER_DEG >> 1;

  localparam int unsigned LO_BITS = 24;
  localparam int unsigned RW      = 26;
  localparam int unsigned AW      = 25;
  localparam int unsigned QW      = 23;
  localparam int unsigned PW      = 22;
  localparam int unsigned XW      = 30;

  localparam logic [127:0] PI_Q32  = 128'd13493037705;
  localparam logic [127:0] RAD_DIV = 128'd180 << (FRAC_BITS + 2);
  localparam int unsigned  RAD_SH  = 48;
  localparam logic [127:0] RAD_K   = ((PI_Q32 << RAD_SH) + RAD_DIV - 128'd1) / RAD_DIV;
  localparam int unsigned  KLO_W   = 29;
  localparam int unsigned  KHI_W   = 28;
  localparam logic [KLO_W-1:0] RAD_K_LO = RAD_K[KLO_W-1:0];
  localparam logic [KHI_W-1:0] RAD_K_HI = RAD_K[KLO_W+KHI_W-1:KLO_W];

  localparam int unsigned SER_STEPS = 5;
  typedef int unsigned div_tbl_t [SER_STEPS];
  localparam div_tbl_t SIN_DIV = '{6, 20, 42, 72, 110};
  localparam div_tbl_t COS_DIV = '{12, 30, 56, 90, 132};

  localparam int unsigned RED_STG = 7;
  localparam int unsigned SER_STG = 2 * SER_STEPS + 2;
  localparam int unsigned MAT_STG = 5;
  localparam int unsigned MAT0    = RED_STG + SER_STG;
  localparam int unsigned N_STG   = MAT0 + MAT_STG;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_e;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] x2;
    logic          swap;
    quad_e         quad;
  } rad_t;

  typedef struct packed {
    logic signed [DW-1:0] sn;
    logic signed [DW-1:0] cs;
  } trig_t;

  typedef logic [AW-1:0] wrap_tbl_t [256];

  // Value of the top angle byte, taken as signed, modulo a full turn.
  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t tbl;
    longint    v;
    for (int i = 0; i < 256; i++) begin
      v = (longint'(i) - ((i >= 128) ? longint'(256) : longint'(0))) * (longint'(1) << LO_BITS);
      while (v >= longint'(FULL_DEG)) begin
        v = v - longint'(FULL_DEG);
      end
      while (v < 0) begin
        v = v + longint'(FULL_DEG);
      end
      tbl[i] = AW'(v);
    end
    return tbl;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap();

endpackage

// ===== hdl/trs_model_matrix_core.sv =====
`timescale 1ns / 1ps
// Model matrix core: translate, rotate (Euler z*y*x) and scale to a 3x4 matrix.
// Depends on tmm_pkg, tmm_reduce, tmm_series and tmm_matrix.
//
// Usage:
// One input word carries position, three angles in degrees and three scales,
// all Q16.16. One output word carries the top three rows of the model matrix.
// Both channels use a valid/ready handshake; a word moves when both are high.
// The pipeline has 24 register stages. Throughput is one word per cycle while
// the output side does not stall; every stage holds one word, and the longest
// path per stage is one multiplier of at most 33 by 32 bits.
// When the receiver stalls, words pile up in empty stages; the input stays
// ready until every stage is full. Nothing is dropped or repeated.
// Reset clears all stage valid bits; data registers are not reset.
// There is no configuration and no state beyond the pipeline.
module trs_model_matrix_core import tmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pos_x, pos_y, pos_z, angle_x_deg, angle_y_deg, angle_z_deg, scale_x, scale_y, scale_z
  input  logic [9*DW-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
  output logic [12*DW-1:0] m_axis_tdata_o
);

  typedef struct packed {
    logic [DW-1:0] scale_z;
    logic [DW-1:0] scale_y;
    logic [DW-1:0] scale_x;
    logic [DW-1:0] pos_z;
    logic [DW-1:0] pos_y;
    logic [DW-1:0] pos_x;
  } side_t;

  logic [N_STG-1:0] vld_q, vld_in, en;
  side_t            side_d;
  side_t            side_q [N_STG];
  rad_t             rad_x, rad_y, rad_z;
  trig_t            trig_x, trig_y, trig_z;
  logic [8:0][DW-1:0] ent;

  always_comb begin
    en[N_STG-1] = !vld_q[N_STG-1] || m_axis_tready_i;
    for (int k = N_STG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_in = {vld_q[N_STG-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N_STG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign side_d.pos_x   = s_axis_tdata_i[1*DW-1:0*DW];
  assign side_d.pos_y   = s_axis_tdata_i[2*DW-1:1*DW];
  assign side_d.pos_z   = s_axis_tdata_i[3*DW-1:2*DW];
  assign side_d.scale_x = s_axis_tdata_i[7*DW-1:6*DW];
  assign side_d.scale_y = s_axis_tdata_i[8*DW-1:7*DW];
  assign side_d.scale_z = s_axis_tdata_i[9*DW-1:8*DW];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_d;
    end
    for (int k = 1; k < N_STG; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  tmm_reduce u_red_x (
    .clk_i   (clk_i),
    .en_i    (en[RED_STG-1:0]),
    .angle_i (s_axis_tdata_i[4*DW-1:3*DW]),
    .rad_o   (rad_x)
  );

  tmm_reduce u_red_y (
    .clk_i   (clk_i),
    .en_i    (en[RED_STG-1:0]),
    .angle_i (s_axis_tdata_i[5*DW-1:4*DW]),
    .rad_o   (rad_y)
  );

  tmm_reduce u_red_z (
    .clk_i   (clk_i),
    .en_i    (en[RED_STG-1:0]),
    .angle_i (s_axis_tdata_i[6*DW-1:5*DW]),
    .rad_o   (rad_z)
  );

  tmm_series u_ser_x (
    .clk_i  (clk_i),
    .en_i   (en[MAT0-1:RED_STG]),
    .rad_i  (rad_x),
    .trig_o (trig_x)
  );

  tmm_series u_ser_y (
    .clk_i  (clk_i),
    .en_i   (en[MAT0-1:RED_STG]),
    .rad_i  (rad_y),
    .trig_o (trig_y)
  );

  tmm_series u_ser_z (
    .clk_i  (clk_i),
    .en_i   (en[MAT0-1:RED_STG]),
    .rad_i  (rad_z),
    .trig_o (trig_z)
  );

  tmm_matrix u_mat (
    .clk_i     (clk_i),
    .en_i      (en[N_STG-1:MAT0]),
    .tx_i      (trig_x),
    .ty_i      (trig_y),
    .tz_i      (trig_z),
    .scale_x_i ($signed(side_q[MAT0+2].scale_x)),
    .scale_y_i ($signed(side_q[MAT0+2].scale_y)),
    .scale_z_i ($signed(side_q[MAT0+2].scale_z)),
    .ent_o     (ent)
  );

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[N_STG-1];
  assign m_axis_tdata_o  = {side_q[N_STG-1].pos_z, ent[8], ent[7], ent[6],
                            side_q[N_STG-1].pos_y, ent[5], ent[4], ent[3],
                            side_q[N_STG-1].pos_x, ent[2], ent[1], ent[0]};

`ifndef SYNTH
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("Input taken while every stage is full and the output stalls.");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("Input not ready although the output side takes words.");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("Accepted word did not reach the first stage.");
`endif

endmodule

// ===== hdl/tmm_reduce.sv =====
`timescale 1ns / 1ps
// Angle reduction: modulo a full turn, quadrant fold and conversion to Q0.30 radians.
// Depends on tmm_pkg.
module tmm_reduce import tmm_pkg::*; (
  input  logic               clk_i,
  input  logic [RED_STG-1:0] en_i,
  input  logic [DW-1:0]      angle_i,
  output rad_t               rad_o
);

  localparam int unsigned PLW  = PW + KLO_W;
  localparam int unsigned PHW  = PW + KHI_W;
  localparam int unsigned SUMW = PHW + KLO_W + 1;

  logic [RW-1:0]   r1_d, r1_q;
  logic [AW-1:0]   r_d, r_q;
  logic [QW-1:0]   rem_d, rem_q;
  quad_e           quad_d, quad2_q, quad3_q, quad4_q, quad5_q;
  logic [PW-1:0]   p_d, p_q;
  logic            swap_d, swap3_q, swap4_q, swap5_q;
  logic [PLW-1:0]  plo_d, plo_q;
  logic [PHW-1:0]  phi_d, phi_q;
  logic [SUMW-1:0] sum;
  logic [XW-1:0]   x_d, x_q;
  logic [2*XW-1:0] sq;
  rad_t            rad_d, rad_q;

  always_comb begin
    r1_d = RW'(WRAP_TBL[angle_i[DW-1:LO_BITS]]) + RW'(angle_i[LO_BITS-1:0]);
    r_d  = (r1_q >= RW'(FULL_DEG)) ? AW'(r1_q - RW'(FULL_DEG)) : AW'(r1_q);

    priority if (r_q >= AW'(3 * QUARTER_DEG)) begin
      quad_d = QUAD_IV;
      rem_d  = QW'(r_q - AW'(3 * QUARTER_DEG));
    end else if (r_q >= AW'(2 * QUARTER_DEG)) begin
      quad_d = QUAD_III;
      rem_d  = QW'(r_q - AW'(2 * QUARTER_DEG));
    end else if (r_q >= AW'(QUARTER_DEG)) begin
      quad_d = QUAD_II;
      rem_d  = QW'(r_q - AW'(QUARTER_DEG));
    end else begin
      quad_d = QUAD_I;
      rem_d  = QW'(r_q);
    end

    swap_d = (rem_q > QW'(HALF_Q_DEG));
    p_d    = swap_d ? PW'(QW'(QUARTER_DEG) - rem_q) : PW'(rem_q);

    plo_d = PLW'(p_q) * PLW'(RAD_K_LO);
    phi_d = PHW'(p_q) * PHW'(RAD_K_HI);

    sum = (SUMW'(phi_q) << KLO_W) + SUMW'(plo_q);
    x_d = XW'(sum >> RAD_SH);

    sq         = (2*XW)'(x_q) * (2*XW)'(x_q);
    rad_d.x    = x_q;
    rad_d.x2   = XW'(sq >> Q_BITS);
    rad_d.swap = swap5_q;
    rad_d.quad = quad5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r1_q <= r1_d;
    end
    if (en_i[1]) begin
      r_q <= r_d;
    end
    if (en_i[2]) begin
      rem_q   <= rem_d;
      quad2_q <= quad_d;
    end
    if (en_i[3]) begin
      p_q     <= p_d;
      swap3_q <= swap_d;
      quad3_q <= quad2_q;
    end
    if (en_i[4]) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      swap4_q <= swap3_q;
      quad4_q <= quad3_q;
    end
    if (en_i[5]) begin
      x_q     <= x_d;
      swap5_q <= swap4_q;
      quad5_q <= quad4_q;
    end
    if (en_i[6]) begin
      rad_q <= rad_d;
    end
  end

  assign rad_o = rad_q;

endmodule

// ===== hdl/tmm_series.sv =====
`timescale 1ns / 1ps
// Pipelined Taylor series for sine and cosine, then the quadrant map.
// Depends on tmm_pkg.
module tmm_series import tmm_pkg::*; (
  input  logic               clk_i,
  input  logic [SER_STG-1:0] en_i,
  input  rad_t               rad_i,
  output trig_t              trig_o
);

  localparam int unsigned PRW = 2 * XW;
  localparam int unsigned DVW = XW + DW;
  localparam logic signed [DW-1:0] ONE_Q = DW'(64'd1 << Q_BITS);
  localparam bit LAST_ODD = (SER_STEPS % 2) == 1;

  typedef struct packed {
    logic [XW-1:0]        x2;
    logic                 swap;
    quad_e                quad;
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] c;
  } carry_t;

  carry_t        ca_q    [SER_STEPS];
  carry_t        cb_q    [SER_STEPS];
  logic [XW-1:0] sprod_q [SER_STEPS];
  logic [XW-1:0] cprod_q [SER_STEPS];
  logic [XW-1:0] sterm_q [SER_STEPS];
  logic [XW-1:0] cterm_q [SER_STEPS];
  carry_t        fin_d, fin_q;
  logic signed [DW-1:0] sv, cv;
  trig_t         trig_d, trig_q;

  for (genvar k = 0; k < SER_STEPS; k++) begin : g_step
    localparam int unsigned SD   = SIN_DIV[k];
    localparam int unsigned CD   = COS_DIV[k];
    localparam int unsigned SSH  = Q_BITS + $clog2(SD);
    localparam int unsigned CSH  = Q_BITS + $clog2(CD);
    localparam logic [DW-1:0] SRCP = DW'(((64'd1 << SSH) + 64'(SD) - 64'd1) / 64'(SD));
    localparam logic [DW-1:0] CRCP = DW'(((64'd1 << CSH) + 64'(CD) - 64'd1) / 64'(CD));
    localparam bit ODD = (k % 2) == 1;

    logic [XW-1:0]  s_src, c_src;
    carry_t         a_d;
    logic [PRW-1:0] s_sq, c_sq;
    logic [DVW-1:0] s_dv, c_dv;

    if (k == 0) begin : g_first
      always_comb begin
        s_src    = rad_i.x;
        c_src    = rad_i.x2 >> 1;
        a_d.x2   = rad_i.x2;
        a_d.swap = rad_i.swap;
        a_d.quad = rad_i.quad;
        a_d.s    = DW'(rad_i.x);
        a_d.c    = ONE_Q - $signed(DW'(rad_i.x2 >> 1));
      end
    end else begin : g_next
      always_comb begin
        s_src = sterm_q[k-1];
        c_src = cterm_q[k-1];
        a_d   = cb_q[k-1];
        if (ODD) begin
          a_d.s = cb_q[k-1].s - $signed(DW'(sterm_q[k-1]));
          a_d.c = cb_q[k-1].c + $signed(DW'(cterm_q[k-1]));
        end else begin
          a_d.s = cb_q[k-1].s + $signed(DW'(sterm_q[k-1]));
          a_d.c = cb_q[k-1].c - $signed(DW'(cterm_q[k-1]));
        end
      end
    end

    always_comb begin
      s_sq = PRW'(s_src) * PRW'(a_d.x2);
      c_sq = PRW'(c_src) * PRW'(a_d.x2);
      s_dv = DVW'(sprod_q[k]) * DVW'(SRCP);
      c_dv = DVW'(cprod_q[k]) * DVW'(CRCP);
    end

    always_ff @(posedge clk_i) begin
      if (en_i[2*k]) begin
        sprod_q[k] <= XW'(s_sq >> Q_BITS);
        cprod_q[k] <= XW'(c_sq >> Q_BITS);
        ca_q[k]    <= a_d;
      end
      if (en_i[2*k+1]) begin
        sterm_q[k] <= XW'(s_dv >> SSH);
        cterm_q[k] <= XW'(c_dv >> CSH);
        cb_q[k]    <= ca_q[k];
      end
    end
  end

  always_comb begin
    fin_d = cb_q[SER_STEPS-1];
    if (LAST_ODD) begin
      fin_d.s = cb_q[SER_STEPS-1].s - $signed(DW'(sterm_q[SER_STEPS-1]));
      fin_d.c = cb_q[SER_STEPS-1].c + $signed(DW'(cterm_q[SER_STEPS-1]));
    end else begin
      fin_d.s = cb_q[SER_STEPS-1].s + $signed(DW'(sterm_q[SER_STEPS-1]));
      fin_d.c = cb_q[SER_STEPS-1].c - $signed(DW'(cterm_q[SER_STEPS-1]));
    end

    sv = fin_q.swap ? fin_q.c : fin_q.s;
    cv = fin_q.swap ? fin_q.s : fin_q.c;
    unique case (fin_q.quad)
      QUAD_I: begin
        trig_d.sn = sv;
        trig_d.cs = cv;
      end
      QUAD_II: begin
        trig_d.sn = cv;
        trig_d.cs = -sv;
      end
      QUAD_III: begin
        trig_d.sn = -sv;
        trig_d.cs = -cv;
      end
      QUAD_IV: begin
        trig_d.sn = -cv;
        trig_d.cs = sv;
      end
      default: begin
        trig_d.sn = sv;
        trig_d.cs = cv;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2*SER_STEPS]) begin
      fin_q <= fin_d;
    end
    if (en_i[2*SER_STEPS+1]) begin
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

// ===== hdl/tmm_matrix.sv =====
`timescale 1ns / 1ps
// Rotation products, per-column scaling, rounding and saturation.
// Depends on tmm_pkg.
module tmm_matrix import tmm_pkg::*; (
  input  logic                 clk_i,
  input  logic [MAT_STG-1:0]   en_i,
  input  trig_t                tx_i,
  input  trig_t                ty_i,
  input  trig_t                tz_i,
  input  logic signed [DW-1:0] scale_x_i,
  input  logic signed [DW-1:0] scale_y_i,
  input  logic signed [DW-1:0] scale_z_i,
  output logic [8:0][DW-1:0]   ent_o
);

  localparam int unsigned RTW   = DW + 1;
  localparam int unsigned PRD_W = RTW + DW;
  localparam int unsigned RND_W = PRD_W + 1;
  localparam logic signed [RND_W-1:0] RND    = RND_W'(64'sd1 <<< (Q_BITS - 1));
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(64'sh7FFFFFFF);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(64'sd1);

  function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] p;
    p = (2*DW)'(a) * (2*DW)'(b);
    return DW'(p >>> Q_BITS);
  endfunction

  logic signed [DW-1:0] czsy_q, szsy_q, sx0_q, cx0_q;
  logic signed [DW-1:0] r00_q, r10_q, r20_q, r21_q, r22_q;
  logic signed [DW-1:0] szcx_q, czcx_q, szsx_q, czsx_q;
  logic signed [DW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [DW-1:0] r00b_q, r10b_q, r20b_q, r21b_q, r22b_q;
  logic signed [DW-1:0] szcxb_q, czcxb_q, szsxb_q, czsxb_q;
  logic signed [RTW-1:0]   rot_d [9];
  logic signed [RTW-1:0]   rot_q [9];
  logic signed [DW-1:0]    sc [3];
  logic signed [PRD_W-1:0] prod_d [9];
  logic signed [PRD_W-1:0] prod_q [9];
  logic signed [RND_W-1:0] rv [9];
  logic [8:0][DW-1:0]      ent_d, ent_q;

  always_comb begin
    rot_d[0] = RTW'(r00b_q);
    rot_d[1] = RTW'(pa_q) - RTW'(szcxb_q);
    rot_d[2] = RTW'(pb_q) + RTW'(szsxb_q);
    rot_d[3] = RTW'(r10b_q);
    rot_d[4] = RTW'(pc_q) + RTW'(czcxb_q);
    rot_d[5] = RTW'(pd_q) - RTW'(czsxb_q);
    rot_d[6] = RTW'(r20b_q);
    rot_d[7] = RTW'(r21b_q);
    rot_d[8] = RTW'(r22b_q);

    sc[0] = scale_x_i;
    sc[1] = scale_y_i;
    sc[2] = scale_z_i;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[3*i + j] = PRD_W'(rot_q[3*i + j]) * PRD_W'(sc[j]);
      end
    end

    for (int i = 0; i < 9; i++) begin
      rv[i] = (RND_W'(prod_q[i]) + RND) >>> Q_BITS;
      if (rv[i] > SAT_HI) begin
        ent_d[i] = DW'(SAT_HI);
      end else if (rv[i] < SAT_LO) begin
        ent_d[i] = DW'(SAT_LO);
      end else begin
        ent_d[i] = DW'(rv[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      czsy_q <= qmul(tz_i.cs, ty_i.sn);
      szsy_q <= qmul(tz_i.sn, ty_i.sn);
      sx0_q  <= tx_i.sn;
      cx0_q  <= tx_i.cs;
      r00_q  <= qmul(tz_i.cs, ty_i.cs);
      r10_q  <= qmul(tz_i.sn, ty_i.cs);
      r20_q  <= -ty_i.sn;
      r21_q  <= qmul(ty_i.cs, tx_i.sn);
      r22_q  <= qmul(ty_i.cs, tx_i.cs);
      szcx_q <= qmul(tz_i.sn, tx_i.cs);
      czcx_q <= qmul(tz_i.cs, tx_i.cs);
      szsx_q <= qmul(tz_i.sn, tx_i.sn);
      czsx_q <= qmul(tz_i.cs, tx_i.sn);
    end
    if (en_i[1]) begin
      pa_q    <= qmul(czsy_q, sx0_q);
      pb_q    <= qmul(czsy_q, cx0_q);
      pc_q    <= qmul(szsy_q, sx0_q);
      pd_q    <= qmul(szsy_q, cx0_q);
      r00b_q  <= r00_q;
      r10b_q  <= r10_q;
      r20b_q  <= r20_q;
      r21b_q  <= r21_q;
      r22b_q  <= r22_q;
      szcxb_q <= szcx_q;
      czcxb_q <= czcx_q;
      szsxb_q <= szsx_q;
      czsxb_q <= czsx_q;
    end
    if (en_i[2]) begin
      rot_q <= rot_d;
    end
    if (en_i[3]) begin
      prod_q <= prod_d;
    end
    if (en_i[4]) begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ===== tb/tb_matrix_checker.sv =====
`timescale 1ns / 1ps
// Checker for the model matrix core: watches both stream channels, computes the
// expected matrix for every accepted input word and compares the output words.
// Depends on tmm_pkg.
module tb_matrix_checker import tmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [9*DW-1:0]  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [12*DW-1:0] out_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  logic [12*DW-1:0] matrix_q [$];

  function automatic longint fdiv2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fdiv2(a * b, 30);
  endfunction

  function automatic void angle_trig(input longint a, output longint sn, output longint cs);
    longint full, quarter, r, q, rem, p, x, x2, term, s, c, t;
    logic [127:0] wide;
    bit swap;
    full = longint'(360) << FRAC_BITS;
    quarter = longint'(90) << FRAC_BITS;
    r = a % full;
    if (r < 0) r = r + full;
    q = r / quarter;
    rem = r - q * quarter;
    swap = rem > (quarter >> 1);
    p = swap ? quarter - rem : rem;
    wide = (128'(p) * PI_Q32) / 128'd180;
    x = longint'(wide >> (FRAC_BITS + 2));
    x2 = (x * x) >> 30;
    s = x;
    term = x;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      s = (k & 1) ? s - term : s + term;
    end
    c = longint'(1) << 30;
    term = c;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
      c = (k & 1) ? c - term : c + term;
    end
    if (swap) begin
      t = s; s = c; c = t;
    end
    case (q & 3)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic [31:0] scaled(longint r, longint sc);
    longint v;
    v = fdiv2(r * sc + (longint'(1) << 29), 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [12*DW-1:0] model_matrix(logic [9*DW-1:0] d);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    longint r [3][3];
    longint sc [3];
    logic [12*DW-1:0] m;
    angle_trig(longint'($signed(d[3*DW +: DW])), sx, cx);
    angle_trig(longint'($signed(d[4*DW +: DW])), sy, cy);
    angle_trig(longint'($signed(d[5*DW +: DW])), sz, cz);
    for (int j = 0; j < 3; j++) sc[j] = longint'($signed(d[(6 + j)*DW +: DW]));
    czsy = qmul(cz, sy);
    szsy = qmul(sz, sy);
    r[0][0] = qmul(cz, cy);
    r[0][1] = qmul(czsy, sx) - qmul(sz, cx);
    r[0][2] = qmul(czsy, cx) + qmul(sz, sx);
    r[1][0] = qmul(sz, cy);
    r[1][1] = qmul(szsy, sx) + qmul(cz, cx);
    r[1][2] = qmul(szsy, cx) - qmul(cz, sx);
    r[2][0] = -sy;
    r[2][1] = qmul(cy, sx);
    r[2][2] = qmul(cy, cx);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) m[(i*4 + j)*DW +: DW] = scaled(r[i][j], sc[j]);
      m[(i*4 + 3)*DW +: DW] = d[i*DW +: DW];
    end
    return m;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    logic [12*DW-1:0] want;
    if (rst_ni && in_valid_i && in_ready_i) begin
      matrix_q.push_back(model_matrix(in_data_i));
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (matrix_q.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (fail_count_o < 10) $display("Unexpected output word %h", out_data_i);
      end else begin
        want = matrix_q.pop_front();
        for (int e = 0; e < 12; e++) begin
          if (want[e*DW +: DW] !== out_data_i[e*DW +: DW]) begin
            if (fail_count_o < 10)
              $display("Entry m%0d%0d: expected %h, got %h", e / 4, e % 4,
                       want[e*DW +: DW], out_data_i[e*DW +: DW]);
            fail_count_o <= fail_count_o + 1;
            break;
          end
        end
      end
    end
    pending_o <= matrix_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the model matrix testbench: clock, reset, stimulus, verdict.
// Depends on tmm_pkg, trs_model_matrix_core and tb_matrix_checker.
module tb_top;
  import tmm_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  logic             s_ready;
  logic [9*DW-1:0]  s_data = '0;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [12*DW-1:0] m_data;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  bit               hold_off = 1'b0;
  bit               inputs_done = 1'b0;

  trs_model_matrix_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data)
  );

  tb_matrix_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_valid), .in_ready_i(s_ready), .in_data_i(s_data),
    .out_valid_i(m_valid), .out_ready_i(m_ready), .out_data_i(m_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] rand_field(int kind);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(($signed($urandom_range(0, 1440)) - 720) <<< FRAC_BITS);
      2: return {{16{1'b0}}, 16'($urandom())} ^ {32{$urandom_range(0, 1) == 1}};
      3: return (kind == 2) ? 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS : $urandom();
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [9*DW-1:0] rand_word();
    logic [9*DW-1:0] w;
    for (int f = 0; f < 9; f++) w[f*DW +: DW] = rand_field(f / 3);
    return w;
  endfunction

  task automatic send_word(logic [9*DW-1:0] w);
    s_valid <= 1'b1;
    s_data  <= w;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic send_gap(int n);
    if (n > 0) begin
      s_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [9*DW-1:0] w;
    logic [31:0] edge_vals [8];
    edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'h005A_0000, 32'h002D_0000, 32'h0168_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int d = 0; d < 8; d++) begin
      for (int f = 0; f < 9; f++) w[f*DW +: DW] = edge_vals[(d + f) % 8];
      send_word(w);
    end
    for (int d = 0; d < 12; d++) begin
      w = '0;
      for (int f = 0; f < 3; f++) w[(6 + f)*DW +: DW] = 32'h0001_0000;
      w[(3 + d % 3)*DW +: DW] = 32'(d * 45) << FRAC_BITS;
      w[DW +: DW] = 32'h0002_D000 + (d % 3);
      send_word(w);
    end
    for (int n = 0; n < 1800; n++) begin
      if (n == 600) hold_off = 1'b1;
      send_word(rand_word());
      if (n > 400 && $urandom_range(0, 2) == 0) send_gap(0);
      else send_gap((n >= 600 && n < 700) ? 0 : gap_len());
    end
    s_valid <= 1'b0;
    inputs_done = 1'b1;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        m_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if ($urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
      m_ready <= 1'b1;
    end
  end

  initial begin
    wait (inputs_done);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hdl/tmm_pkg.sv
hdl/tmm_reduce.sv
hdl/tmm_series.sv
hdl/tmm_matrix.sv
hdl/trs_model_matrix_core.sv
tb/tb_matrix_checker.sv
tb/tb_top.sv
